// ===== rtl/core/rtd_pkg.sv =====
// ----------------------------------------------------------------------------
// rtd_pkg
// Shared status codes and field widths for the run-length token decoder.
// ----------------------------------------------------------------------------
package rtd_pkg;

    localparam int DATA_W   = 64;
    localparam int COUNT_W  = 4;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 24;
    localparam int MAX_LANES = 8;

    localparam logic [STATUS_W-1:0] ST_DATA      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CAP       = 2'd3;

endpackage

// ===== rtl/core/rle_token_decompressor.sv =====
// Control, non-final literal and skipped bytes are consumed in the input state.
// A run value releases ceil(n / lanes) results, one per cycle while not stalled.
// A closed literal token drains through the memory read port, one result every
//   lanes bytes; a status result, when due, follows the last data result.
// Input stalls in the run, literal and status states. Reset clears control and
//   output state; the literal buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// rle_token_decompressor
// Decodes a run-length byte stream into packed output words with cap and
// malformed-stream checking. Literal bytes are buffered in a 128-entry memory.
// ----------------------------------------------------------------------------
module rle_token_decompressor #(
    parameter int OUT_BYTES = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rtd_pkg::CAP_W-1:0]      cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     in_byte,
    input  logic                           in_last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rtd_pkg::DATA_W-1:0]     out_data,
    output logic [rtd_pkg::COUNT_W-1:0]    out_count,
    output logic [rtd_pkg::STATUS_W-1:0]   out_status,
    output logic                           out_last
);

    localparam int LANES  = (OUT_BYTES > rtd_pkg::MAX_LANES) ? rtd_pkg::MAX_LANES :
                            ((OUT_BYTES < 1) ? 1 : OUT_BYTES);
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam logic [LANE_W-1:0] LANE_TOP = LANE_W'(LANES - 1);
    localparam logic [7:0] LANES_B = 8'(LANES);
    localparam int CW = rtd_pkg::CAP_W;

    typedef enum logic [1:0] {S_IN, S_RUN, S_LIT, S_STAT} state_t;
    typedef enum logic [1:0] {P_CTRL, P_RUNVAL, P_LIT, P_SKIP} phase_t;

    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [6:0]             tok_reg, tok_next;
    logic [6:0]             fill_reg, fill_next;
    logic [CW-1:0]          total_reg, total_next;
    logic [CW-1:0]          cap_reg, cap_next;
    logic                   tail_ok_reg, tail_ok_next;
    logic [1:0]             stat_reg, stat_next;
    logic [7:0]             run_byte_reg, run_byte_next;
    logic [7:0]             remain_reg, remain_next;
    logic [7:0]             n_reg, n_next;
    logic [7:0]             rd_cnt_reg, rd_cnt_next;
    logic [7:0]             got_cnt_reg, got_cnt_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [LANE_W-1:0]      lane_reg, lane_next;
    logic [63:0]            pack_reg, pack_next;
    logic                   out_valid_reg, out_valid_next;
    logic [63:0]            out_data_reg, out_data_next;
    logic [3:0]             out_count_reg, out_count_next;
    logic [1:0]             out_status_reg, out_status_next;
    logic                   out_last_reg, out_last_next;

    logic [7:0]             lit_mem [128];
    logic [7:0]             rd_data_reg;
    logic                   mem_we;
    logic                   mem_re;

    logic                   accept;
    logic                   out_free;
    logic [7:0]             tok_len;
    logic [CW:0]            sum;
    logic                   over_cap;
    logic [7:0]             chunk;
    logic                   run_final;
    logic [63:0]            run_word;
    logic [63:0]            lit_word;
    logic                   lit_final;
    logic                   chunk_end;
    logic                   cap_ok;
    logic                   release_tok;

    assign in_stall   = (state_reg != S_IN);
    assign accept     = in_valid && (state_reg == S_IN);
    assign out_free   = !out_valid_reg || !out_stall;
    assign tok_len    = {1'b0, tok_reg} + 8'd1;
    assign sum        = {1'b0, total_reg} + {{(CW - 7){1'b0}}, tok_len};
    assign over_cap   = sum > {1'b0, cap_reg};
    assign chunk      = (remain_reg >= LANES_B) ? LANES_B : remain_reg;
    assign run_final  = (remain_reg <= LANES_B);
    assign lit_word   = pack_reg | ({56'd0, rd_data_reg} << {lane_reg, 3'b000});
    assign lit_final  = (got_cnt_reg + 8'd1 == n_reg);
    assign chunk_end  = (lane_reg == LANE_TOP) || lit_final;
    assign cap_ok     = (state_reg == S_LIT) && rd_pend_reg && (!chunk_end || out_free);
    assign mem_re     = (state_reg == S_LIT) && (rd_cnt_reg < n_reg) && (!rd_pend_reg || cap_ok);

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            run_word[8*i +: 8] = (8'(i) < chunk) ? run_byte_reg : 8'd0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        tok_next        = tok_reg;
        fill_next       = fill_reg;
        total_next      = total_reg;
        cap_next        = cfg_we ? cfg_wdata : cap_reg;
        tail_ok_next    = tail_ok_reg;
        stat_next       = stat_reg;
        run_byte_next   = run_byte_reg;
        remain_next     = remain_reg;
        n_next          = n_reg;
        rd_cnt_next     = rd_cnt_reg;
        got_cnt_next    = got_cnt_reg;
        rd_pend_next    = rd_pend_reg;
        lane_next       = lane_reg;
        pack_next       = pack_reg;
        out_valid_next  = out_stall ? out_valid_reg : 1'b0;
        out_data_next   = out_data_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        release_tok     = 1'b0;

        unique case (state_reg)
            S_IN:
            begin
                if (accept)
                begin
                    unique case (phase_reg)
                        P_CTRL:
                        begin
                            tok_next  = in_byte[6:0];
                            fill_next = 7'd0;
                            if (in_last)
                            begin
                                stat_next  = rtd_pkg::ST_MALFORMED;
                                state_next = S_STAT;
                                total_next = '0;
                            end
                            else
                            begin
                                phase_next = in_byte[7] ? P_RUNVAL : P_LIT;
                            end
                        end
                        P_RUNVAL:
                        begin
                            release_tok = 1'b1;
                        end
                        P_LIT:
                        begin
                            mem_we    = 1'b1;
                            fill_next = fill_reg + 7'd1;
                            if (fill_reg == tok_reg)
                            begin
                                release_tok = 1'b1;
                            end
                            else if (in_last)
                            begin
                                stat_next  = rtd_pkg::ST_MALFORMED;
                                state_next = S_STAT;
                                phase_next = P_CTRL;
                                total_next = '0;
                            end
                        end
                        default:
                        begin
                            if (in_last)
                            begin
                                phase_next = P_CTRL;
                                total_next = '0;
                            end
                        end
                    endcase

                    if (release_tok)
                    begin
                        if (over_cap)
                        begin
                            stat_next  = rtd_pkg::ST_CAP;
                            state_next = S_STAT;
                            phase_next = in_last ? P_CTRL : P_SKIP;
                            if (in_last)
                            begin
                                total_next = '0;
                            end
                        end
                        else
                        begin
                            total_next   = in_last ? '0 : sum[CW-1:0];
                            phase_next   = P_CTRL;
                            tail_ok_next = in_last;
                            if (phase_reg == P_RUNVAL)
                            begin
                                run_byte_next = in_byte;
                                remain_next   = tok_len;
                                state_next    = S_RUN;
                            end
                            else
                            begin
                                n_next       = tok_len;
                                rd_cnt_next  = 8'd0;
                                got_cnt_next = 8'd0;
                                rd_pend_next = 1'b0;
                                lane_next    = '0;
                                pack_next    = '0;
                                state_next   = S_LIT;
                            end
                        end
                    end
                end
            end
            S_RUN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = run_word;
                    out_count_next  = chunk[3:0];
                    out_status_next = rtd_pkg::ST_DATA;
                    out_last_next   = run_final && !tail_ok_reg;
                    remain_next     = remain_reg - chunk;
                    if (run_final)
                    begin
                        stat_next  = rtd_pkg::ST_OK;
                        state_next = tail_ok_reg ? S_STAT : S_IN;
                    end
                end
            end
            S_LIT:
            begin
                if (mem_re)
                begin
                    rd_cnt_next  = rd_cnt_reg + 8'd1;
                    rd_pend_next = 1'b1;
                end
                else if (cap_ok)
                begin
                    rd_pend_next = 1'b0;
                end
                if (cap_ok)
                begin
                    got_cnt_next = got_cnt_reg + 8'd1;
                    if (chunk_end)
                    begin
                        out_valid_next  = 1'b1;
                        out_data_next   = lit_word;
                        out_count_next  = 4'({1'b0, lane_reg}) + 4'd1;
                        out_status_next = rtd_pkg::ST_DATA;
                        out_last_next   = lit_final && !tail_ok_reg;
                        pack_next       = '0;
                        lane_next       = '0;
                    end
                    else
                    begin
                        pack_next = lit_word;
                        lane_next = lane_reg + LANE_W'(1);
                    end
                    if (lit_final)
                    begin
                        stat_next  = rtd_pkg::ST_OK;
                        state_next = tail_ok_reg ? S_STAT : S_IN;
                    end
                end
            end
            default:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = '0;
                    out_count_next  = 4'd0;
                    out_status_next = stat_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IN;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IN;
            phase_reg      <= P_CTRL;
            tok_reg        <= '0;
            fill_reg       <= '0;
            total_reg      <= '0;
            cap_reg        <= '1;
            tail_ok_reg    <= 1'b0;
            stat_reg       <= rtd_pkg::ST_DATA;
            run_byte_reg   <= '0;
            remain_reg     <= '0;
            n_reg          <= '0;
            rd_cnt_reg     <= '0;
            got_cnt_reg    <= '0;
            rd_pend_reg    <= 1'b0;
            lane_reg       <= '0;
            pack_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_count_reg  <= '0;
            out_status_reg <= rtd_pkg::ST_DATA;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            tok_reg        <= tok_next;
            fill_reg       <= fill_next;
            total_reg      <= total_next;
            cap_reg        <= cap_next;
            tail_ok_reg    <= tail_ok_next;
            stat_reg       <= stat_next;
            run_byte_reg   <= run_byte_next;
            remain_reg     <= remain_next;
            n_reg          <= n_next;
            rd_cnt_reg     <= rd_cnt_next;
            got_cnt_reg    <= got_cnt_next;
            rd_pend_reg    <= rd_pend_next;
            lane_reg       <= lane_next;
            pack_reg       <= pack_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            out_count_reg  <= out_count_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    // literal buffer: written while gathering, drained after the token closes
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lit_mem[fill_reg] <= in_byte;
        end
        if (mem_re)
        begin
            rd_data_reg <= lit_mem[rd_cnt_reg[6:0]];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_count  = out_count_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

// ===== rtl/core/rtd_checker.sv =====
// ----------------------------------------------------------------------------
// rtd_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
module rtd_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [rtd_pkg::DATA_W-1:0]     out_data,
    input  logic [rtd_pkg::COUNT_W-1:0]    out_count,
    input  logic [rtd_pkg::STATUS_W-1:0]   out_status,
    input  logic                           out_last
);

    // status results are empty and close the request's result group
    a_status_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status != rtd_pkg::ST_DATA)
        |-> (out_count == 4'd0) && (out_data == '0) && out_last)
        else $error("status result carries data");

    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == rtd_pkg::ST_DATA)
        |-> (out_count != 4'd0) && (out_count <= 4'(rtd_pkg::MAX_LANES)))
        else $error("data result count out of range");

    a_unused_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == rtd_pkg::ST_DATA) && (out_count < 4'd8)
        |-> ((out_data >> {out_count, 3'b000}) == '0))
        else $error("unused output lanes not zero");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall
        |=> out_valid && $stable(out_data) && $stable(out_count)
            && $stable(out_status) && $stable(out_last))
        else $error("stalled result changed");

endmodule

bind rle_token_decompressor rtd_checker u_rtd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .out_count  (out_count),
    .out_status (out_status),
    .out_last   (out_last)
);
